@@ sv/lspf_pkg.sv @@
// Shared types and constants for the looped sample player with fade.
// Holds operation and register codes, sizing constants and address helpers.
// No dependencies.
package lspf_pkg;

   // Sample store geometry
   localparam int SAMPLE_DEPTH = 65536;
   localparam int SAMPLE_BITS  = 16;
   localparam int ADDR_BITS    = $clog2(SAMPLE_DEPTH);

   // Low bits cleared on load when the store keeps fewer than 16 bits
   localparam int          QUANT_BITS = (SAMPLE_BITS < 16) ? (16 - SAMPLE_BITS) : 0;
   localparam logic [15:0] KEEP_MASK  = 16'hFFFF << QUANT_BITS;

   // Field and register widths
   localparam int OP_BITS       = 2;
   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 16;
   localparam int RAMP_LEN_W    = 16;
   localparam int NOTE_LEN_W    = 24;
   localparam int LOOP_LEN_W    = 17;
   localparam int LOOP_PTR_W    = 16;
   localparam int RAMP_W        = 18;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 24;

   // Arithmetic widths
   localparam int ABS_W   = SAMPLE_W + 1;               // magnitude of a sample
   localparam int MAG0_W  = ABS_W + GAIN_W;             // sample times gain
   localparam int PROD_W  = MAG0_W + RAMP_W;            // times ramp level
   localparam int FRAC_W  = 15;                         // Q1.15 gain scaling
   localparam int DVD_W   = PROD_W - FRAC_W;            // dividend after the shift
   localparam int CNT_W   = $clog2(DVD_W);

   // Reset values
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = 16'd32768;
   localparam logic [RAMP_LEN_W-1:0] RAMP_LEN_RESET = 16'd1000;
   localparam logic [NOTE_LEN_W-1:0] NOTE_LEN_RESET = 24'd44100;
   localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_RESET = 17'd65536;
   localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_FULL  = 17'd65536;
   localparam logic [RAMP_W-1:0]     RAMP_MAX       = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_PLAY  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN     = 2'd0,
      CSR_RAMP_LEN = 2'd1,
      CSR_NOTE_LEN = 2'd2,
      CSR_LOOP_LEN = 2'd3
   } csr_index_type;

   // Map a 16-bit address onto the store, wrapping at its depth
   function automatic logic [ADDR_BITS-1:0] store_addr(input logic [15:0] a);
      logic [31:0] wide;
      wide = {16'd0, a};
      return wide[ADDR_BITS-1:0];
   endfunction

endpackage

@@ sv/looped_sample_player_with_fade.sv @@
// Looped sample player with a linear fade envelope. Load items (op 0) write one
// sample word into the store; a start item (op 2) clears the position, loop
// pointer and ramp level; op 3 is dropped. A play item (op 1) passes through the
// synchronous store read, the gain and ramp multiplies (S_MUL1, S_MUL2), the
// bit-serial divide by ramp_length (S_DIV), and S_DONE, which saturates and
// hands the sum to the output register. A play item past the note end goes
// straight to S_DONE and passes mix_in through with past_end set. The
// output register lets the next item be accepted while a result waits on
// rsp_stall. Configuration must be written only while the block is idle.
// Depends on lspf_pkg.
module looped_sample_player_with_fade (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lspf_pkg::OP_BITS-1:0]        req_op,
   input  logic [15:0]                         req_load_address,
   input  logic signed [lspf_pkg::SAMPLE_W-1:0] req_load_value,
   input  logic signed [lspf_pkg::SAMPLE_W-1:0] req_mix_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lspf_pkg::SAMPLE_W-1:0] rsp_mix_out,
   output logic                                rsp_past_end,
   input  logic                                csr_write_enable,
   input  logic [lspf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lspf_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import lspf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL1 = 5'b00010,
      S_MUL2 = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   // Configuration registers
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [RAMP_LEN_W-1:0] ramp_len_ff, ramp_len_in;
   logic [NOTE_LEN_W-1:0] note_len_ff, note_len_in;
   logic [LOOP_LEN_W-1:0] loop_len_ff, loop_len_in;

   // Note state
   logic [NOTE_LEN_W-1:0] position_ff, position_in;
   logic [LOOP_PTR_W-1:0] loop_ptr_ff, loop_ptr_in;
   logic [RAMP_W-1:0]     ramp_ff, ramp_in;

   // Control
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working payload
   logic [RAMP_W-1:0]          ramp_work_ff, ramp_work_in;
   logic signed [SAMPLE_W-1:0] mix_ff, mix_in;
   logic                       past_ff, past_in;
   logic                       neg_ff, neg_in;
   logic [MAG0_W-1:0]          mag0_ff, mag0_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [RAMP_LEN_W-1:0]      rem_ff, rem_in;
   logic signed [SAMPLE_W-1:0] out_mix_ff, out_mix_in;
   logic                       out_past_ff, out_past_in;

   // Sample store
   logic [SAMPLE_W-1:0] store [SAMPLE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                mem_write;
   logic                mem_read;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [ADDR_BITS-1:0] mem_raddr;

   // Datapath helpers
   logic                   accept;
   logic                   play_go;
   logic                   is_past;
   logic [RAMP_LEN_W-1:0]  rl;
   logic [LOOP_LEN_W-1:0]  ll;
   logic [LOOP_LEN_W-1:0]  idx;
   logic [LOOP_LEN_W-1:0]  idx_next;
   logic                   rise;
   logic                   fall;
   logic [RAMP_W-1:0]      ramp_up;
   logic [ABS_W-1:0]       smp_ext;
   logic [ABS_W-1:0]       smp_abs;
   logic [PROD_W-1:0]      product;
   logic [RAMP_LEN_W:0]    rem_sh;
   logic                   rem_ge;
   logic [ABS_W-1:0]       q_sat;
   logic signed [ABS_W:0]  contrib;
   logic signed [ABS_W:0]  sum;
   logic signed [SAMPLE_W-1:0] sum_sat;
   logic                   out_free;

   assign req_stall    = (state_ff != S_IDLE);
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mix_out  = out_mix_ff;
   assign rsp_past_end = out_past_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Effective ramp and loop lengths, current read index and its successor
   always_comb begin
      rl = (ramp_len_ff == '0) ? RAMP_LEN_W'(1) : ramp_len_ff;
      ll = (loop_len_ff == '0 || loop_len_ff > LOOP_LEN_FULL) ? LOOP_LEN_FULL : loop_len_ff;
      idx = ({1'b0, loop_ptr_ff} < ll) ? {1'b0, loop_ptr_ff} : '0;
      idx_next = idx + LOOP_LEN_W'(1);
      if (idx_next >= ll) begin
         idx_next = '0;
      end
      is_past = (position_ff >= note_len_ff);
      rise = (position_ff < NOTE_LEN_W'(rl - RAMP_LEN_W'(1))) && (ramp_ff < RAMP_MAX);
      fall = ({1'b0, position_ff} + (NOTE_LEN_W + 1)'(rl)) >= {1'b0, note_len_ff};
      ramp_up = rise ? (ramp_ff + RAMP_W'(1)) : ramp_ff;
   end

   assign play_go   = accept && (op_type'(req_op) == OP_PLAY) && !is_past;
   assign mem_write = accept && (op_type'(req_op) == OP_LOAD);
   assign mem_read  = play_go;
   assign mem_waddr = store_addr(req_load_address);
   assign mem_raddr = store_addr(idx[LOOP_PTR_W-1:0]);

   // Store write on load, registered read on play
   always_ff @(posedge clock) begin
      if (mem_write) begin
         store[mem_waddr] <= req_load_value & KEEP_MASK;
      end
      if (mem_read) begin
         rd_data_ff <= store[mem_raddr];
      end
   end

   // Sample magnitude, ramp multiply and one divider step
   always_comb begin
      smp_ext = {rd_data_ff[SAMPLE_W-1], rd_data_ff};
      smp_abs = rd_data_ff[SAMPLE_W-1] ? (~smp_ext + ABS_W'(1)) : smp_ext;
      product = PROD_W'(mag0_ff) * PROD_W'(ramp_work_ff);
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      rem_ge  = (rem_sh >= {1'b0, rl});
   end

   // Saturate the quotient and the sum
   always_comb begin
      q_sat = (|dvd_ff[DVD_W-1:SAMPLE_W]) ? {1'b0, {SAMPLE_W{1'b1}}}
                                          : {1'b0, dvd_ff[SAMPLE_W-1:0]};
      contrib = neg_ff ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      sum = $signed({{2{mix_ff[SAMPLE_W-1]}}, mix_ff}) + contrib;
      if (sum > $signed((ABS_W + 1)'(32767))) begin
         sum_sat = 16'sh7FFF;
      end else if (sum < -$signed((ABS_W + 1)'(32768))) begin
         sum_sat = -16'sh8000;
      end else begin
         sum_sat = sum[SAMPLE_W-1:0];
      end
   end

   // Next-state logic
   always_comb begin
      gain_in      = gain_ff;
      ramp_len_in  = ramp_len_ff;
      note_len_in  = note_len_ff;
      loop_len_in  = loop_len_ff;
      position_in  = position_ff;
      loop_ptr_in  = loop_ptr_ff;
      ramp_in      = ramp_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ramp_work_in = ramp_work_ff;
      mix_in       = mix_ff;
      past_in      = past_ff;
      neg_in       = neg_ff;
      mag0_in      = mag0_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      out_mix_in   = out_mix_ff;
      out_past_in  = out_past_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Configuration writes
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN:     gain_in     = csr_write_data[GAIN_W-1:0];
            CSR_RAMP_LEN: ramp_len_in = csr_write_data[RAMP_LEN_W-1:0];
            CSR_NOTE_LEN: note_len_in = csr_write_data[NOTE_LEN_W-1:0];
            CSR_LOOP_LEN: loop_len_in = csr_write_data[LOOP_LEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_START: begin
                     position_in = '0;
                     loop_ptr_in = '0;
                     ramp_in     = '0;
                  end
                  OP_PLAY: begin
                     mix_in  = req_mix_in;
                     past_in = is_past;
                     if (is_past) begin
                        state_in = S_DONE;
                     end else begin
                        // Advance note state, keep the old ramp for scaling
                        ramp_work_in = ramp_ff;
                        ramp_in      = (fall && ramp_up != '0) ? (ramp_up - RAMP_W'(1))
                                                                : ramp_up;
                        loop_ptr_in  = idx_next[LOOP_PTR_W-1:0];
                        position_in  = position_ff + NOTE_LEN_W'(1);
                        state_in     = S_MUL1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL1: begin
            neg_in   = rd_data_ff[SAMPLE_W-1];
            mag0_in  = MAG0_W'(smp_abs) * MAG0_W'(gain_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            // Drop the Q1.15 fraction and start the divide
            dvd_in   = product[PROD_W-1:FRAC_W];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = rem_ge ? RAMP_LEN_W'(rem_sh - {1'b0, rl}) : rem_sh[RAMP_LEN_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               out_mix_in   = past_ff ? mix_ff : sum_sat;
               out_past_in  = past_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         ramp_len_ff  <= RAMP_LEN_RESET;
         note_len_ff  <= NOTE_LEN_RESET;
         loop_len_ff  <= LOOP_LEN_RESET;
         position_ff  <= '0;
         loop_ptr_ff  <= '0;
         ramp_ff      <= '0;
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         ramp_len_ff  <= ramp_len_in;
         note_len_ff  <= note_len_in;
         loop_len_ff  <= loop_len_in;
         position_ff  <= position_in;
         loop_ptr_ff  <= loop_ptr_in;
         ramp_ff      <= ramp_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ramp_work_ff <= ramp_work_in;
      mix_ff       <= mix_in;
      past_ff      <= past_in;
      neg_ff       <= neg_in;
      mag0_ff      <= mag0_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      out_mix_ff   <= out_mix_in;
      out_past_ff  <= out_past_in;
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench for looped_sample_player_with_fade: directed and random item streams,
// checked against an in-bench predictor of the player. Depends on lspf_pkg and the DUT.
module tb;
   import lspf_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 50;
   localparam int PHASE_ITEMS    = 200;
   localparam int HOLDOFF_CYCLES = 400;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mix_out;
      logic                       past_end;
   } mix_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [OP_BITS-1:0]           req_op = '0;
   logic [15:0]                  req_load_address = '0;
   logic signed [SAMPLE_W-1:0]   req_load_value = '0;
   logic signed [SAMPLE_W-1:0]   req_mix_in = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_mix_out;
   logic                         rsp_past_end;
   logic                         csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_write_data = '0;

   // Player state as the bench sees it
   logic [15:0]             store_image [0:65535];
   bit                      store_written [0:65535];
   logic [NOTE_LEN_W-1:0]   note_pos = '0;
   logic [LOOP_PTR_W-1:0]   loop_ptr = '0;
   logic [RAMP_W-1:0]       ramp_lvl = '0;
   logic [GAIN_W-1:0]       gain_reg = GAIN_RESET;
   logic [RAMP_LEN_W-1:0]   ramp_len_reg = RAMP_LEN_RESET;
   logic [NOTE_LEN_W-1:0]   note_len_reg = NOTE_LEN_RESET;
   logic [LOOP_LEN_W-1:0]   loop_len_reg = LOOP_LEN_RESET;

   mix_result_type expected_mix [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holdoff_token  = 0;
   int holdoff_seen   = 0;
   int holdoff_left   = 0;
   int error_count    = 0;
   int items_sent     = 0;
   int cycle_count    = 0;

   looped_sample_player_with_fade DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Loop length as the player applies it
   function automatic logic [LOOP_LEN_W-1:0] loop_span();
      return (loop_len_reg == 0 || loop_len_reg > LOOP_LEN_FULL) ? LOOP_LEN_FULL : loop_len_reg;
   endfunction

   // Store entry the next play inside the note reads
   function automatic logic [15:0] read_index();
      return ({1'b0, loop_ptr} < loop_span()) ? loop_ptr : 16'd0;
   endfunction

   // Advance the player state by one transfer and queue the result it owes
   function automatic void apply_item(input op_type op, input logic [15:0] addr,
                                      input logic signed [15:0] val,
                                      input logic signed [15:0] mix);
      int unsigned        rl;
      logic [15:0]        idx;
      logic [LOOP_LEN_W:0] next_ptr;
      longint             smp;
      longint             contrib;
      longint             total;
      longint unsigned    mag;
      longint unsigned    quot;
      mix_result_type     res;
      case (op)
         OP_LOAD: begin
            store_image[addr]   = val & KEEP_MASK;
            store_written[addr] = 1'b1;
         end
         OP_START: begin
            note_pos = '0;
            loop_ptr = '0;
            ramp_lvl = '0;
         end
         OP_PLAY: begin
            if (note_pos >= note_len_reg) begin
               res.mix_out  = mix;
               res.past_end = 1'b1;
            end else begin
               rl   = (ramp_len_reg == 0) ? 32'd1 : 32'(ramp_len_reg);
               idx  = read_index();
               smp  = longint'($signed(store_image[idx]));
               mag  = (smp < 0) ? -smp : smp;
               mag  = mag * gain_reg;
               mag  = mag * ramp_lvl;
               quot = mag / (64'd32768 * rl);
               contrib = (smp < 0) ? -longint'(quot) : longint'(quot);
               total   = longint'(mix) + contrib;
               if (total > 32767) total = 32767;
               if (total < -32768) total = -32768;
               res.mix_out  = total[15:0];
               res.past_end = 1'b0;
               // Rise during the fade in, fall during the fade out
               if (note_pos < rl - 1 && ramp_lvl < RAMP_MAX) ramp_lvl = ramp_lvl + 1'b1;
               if (longint'(note_pos) + rl >= note_len_reg && ramp_lvl != 0)
                  ramp_lvl = ramp_lvl - 1'b1;
               next_ptr = {1'b0, idx} + 1'b1;
               if (next_ptr >= loop_span()) next_ptr = '0;
               loop_ptr = next_ptr[15:0];
               note_pos = note_pos + 1'b1;
            end
            expected_mix.insert(expected_mix.size(), res);
         end
         default: ;
      endcase
   endfunction

   function automatic logic signed [15:0] random_mix();
      case ($urandom_range(15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one transfer, with random idle cycles ahead of it
   task automatic send_item(input op_type op, input logic [15:0] addr,
                            input logic signed [15:0] val, input logic signed [15:0] mix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_load_address <= addr;
      req_load_value   <= val;
      req_mix_in       <= mix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_item(op, addr, val, mix);
      items_sent++;
   endtask

   // Play one sample; fill the store entry first if the note would read it unwritten
   task automatic play_sample(input logic signed [15:0] mix);
      if (note_pos < note_len_reg && !store_written[read_index()])
         send_item(OP_LOAD, read_index(), 16'($urandom), random_mix());
      send_item(OP_PLAY, 16'($urandom), 16'($urandom), mix);
   endtask

   // Hold the input and let every owed result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_mix.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_GAIN:     gain_reg     = data[GAIN_W-1:0];
         CSR_RAMP_LEN: ramp_len_reg = data[RAMP_LEN_W-1:0];
         CSR_NOTE_LEN: note_len_reg = data[NOTE_LEN_W-1:0];
         default:      loop_len_reg = data[LOOP_LEN_W-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] gain, input logic [CSR_DATA_W-1:0] ramp,
                            input logic [CSR_DATA_W-1:0] note, input logic [CSR_DATA_W-1:0] span);
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_RAMP_LEN, ramp);
      write_reg(CSR_NOTE_LEN, note);
      write_reg(CSR_LOOP_LEN, span);
   endtask

   // 0: none, 1: sender idles, 2: receiver stalls, 3: both
   task automatic set_idling(input int mode);
      send_idle_pct  = (mode == 1) ? 64 : (mode == 3) ? 30 : 0;
      recv_stall_pct <= (mode == 2) ? 64 : (mode == 3) ? 30 : 0;
   endtask

   // One note: mostly plays, with stray loads, ignored ops and restarts mixed in
   task automatic run_note(input bit with_start);
      int plays;
      int pick;
      plays = $urandom_range(80, 1);
      if (with_start) send_item(OP_START, 16'($urandom), 16'($urandom), random_mix());
      repeat (plays) begin
         pick = $urandom_range(99);
         if (pick < 6)
            send_item(OP_LOAD, $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(63)),
                      16'($urandom), random_mix());
         else if (pick < 9)
            send_item(OP_NONE, 16'($urandom), 16'($urandom), random_mix());
         else if (pick < 11)
            send_item(OP_START, 16'($urandom), 16'($urandom), random_mix());
         else
            play_sample(random_mix());
      end
      if ($urandom_range(7) == 0) wait_idle();
   endtask

   // The first note carries on from the previous setting, so the change lands mid-note
   task automatic run_phase(input logic [CSR_DATA_W-1:0] gain, input logic [CSR_DATA_W-1:0] ramp,
                            input logic [CSR_DATA_W-1:0] note, input logic [CSR_DATA_W-1:0] span,
                            input int mode);
      int target;
      wait_idle();
      configure(gain, ramp, note, span);
      set_idling(mode);
      target = items_sent + PHASE_ITEMS;
      run_note(1'b0);
      while (items_sent < target) run_note(1'b1);
   endtask

   // Plays straight out of reset use the reset register values
   task automatic test_reset_values();
      send_item(OP_LOAD, 16'd0, 16'sh7FFF, 16'sd0);
      send_item(OP_LOAD, 16'd1, 16'sh8000, 16'sd0);
      play_sample(16'sd10);
      play_sample(-16'sd10);
      play_sample(16'sd0);
   endtask

   // Short note across the whole fade, loop wrap, saturation and the note end
   task automatic test_directed();
      wait_idle();
      configure(24'd32768, 24'd2, 24'd6, 24'd3);
      send_item(OP_LOAD, 16'd0, 16'sh7FFF, 16'sd0);
      send_item(OP_LOAD, 16'd1, 16'sh8000, 16'sd0);
      send_item(OP_LOAD, 16'd2, -16'sd3, 16'sd0);
      send_item(OP_LOAD, 16'hFFFF, -16'sd1, 16'sd0);
      send_item(OP_NONE, 16'hFFFF, 16'sh7FFF, 16'sh7FFF);
      send_item(OP_START, 16'd0, 16'sd0, 16'sd0);
      play_sample(16'sd1234);
      play_sample(16'sh8000);
      play_sample(16'sd0);
      play_sample(16'sh7FFF);
      play_sample(16'sd100);
      play_sample(-16'sd5);
      play_sample(16'sd77);
      play_sample(16'sh8000);
   endtask

   // Hold off the receiver while the sender keeps offering plays
   task automatic test_backpressure();
      wait_idle();
      configure(24'd32768, 24'd3, 24'd200, 24'd5);
      set_idling(0);
      send_item(OP_START, 16'd0, 16'sd0, 16'sd0);
      holdoff_token <= holdoff_token + 1;
      repeat (12) play_sample(random_mix());
      wait_idle();
   endtask

   task automatic test_random_settings();
      run_phase(24'd32768, 24'd4, 24'd40, 24'd16, 0);
      run_phase(24'd0, 24'd1, 24'd30, 24'd1, 1);
      run_phase(24'd12000, 24'd0, 24'd25, 24'd0, 2);
      run_phase(24'd32768, 24'd65535, 24'hFFFFFF, 24'd131071, 3);
      run_phase(24'($urandom_range(32768)), 24'd10, 24'd0, 24'd65536, 0);
      run_phase(24'd20000, 24'd20, 24'd60, 24'd7, 1);
      run_phase(24'($urandom_range(32768)), 24'($urandom_range(30, 1)),
                24'($urandom_range(120, 1)), 24'($urandom_range(50, 1)), 2);
      run_phase(24'd32768, 24'd3, 24'd16, 24'd65536, 3);
   endtask

   // Count down a long receiver hold-off once one is requested
   always @(posedge clock) begin
      if (holdoff_seen != holdoff_token) begin
         holdoff_seen <= holdoff_token;
         holdoff_left <= HOLDOFF_CYCLES;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Check each result transfer against the oldest owed result; pick the next stall
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_mix.size() == 0) begin
            $error("result transfer with nothing expected: mix_out %0d past_end %0b",
                   rsp_mix_out, rsp_past_end);
            error_count++;
         end else begin
            want = expected_mix.pop_front();
            if (rsp_mix_out !== want.mix_out) begin
               $error("mix_out: expected %0d, got %0d", want.mix_out, rsp_mix_out);
               error_count++;
            end
            if (rsp_past_end !== want.past_end) begin
               $error("past_end: expected %0b, got %0b", want.past_end, rsp_past_end);
               error_count++;
            end
         end
      end
      if (holdoff_left != 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_backpressure();
      test_random_settings();
      wait_idle();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
